// ===== sv/mrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types for the motor reversal sequencer: command beat, result beat
// and configuration bundle.
// ----------------------------------------------------------------------------
package mrs_pkg;

  // register indexes of the configuration port
  localparam logic CFG_MEAS_INTERVAL = 1'b0;
  localparam logic CFG_SETTLE_TIME   = 1'b1;

  // widths of the stream payloads
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 32;

  // one millisecond tick of commands
  typedef struct packed {
    logic [7:0]        hall_pulses;
    logic              speed_write;
    logic signed [8:0] speed_value;
    logic              elec_req_write;
    logic              elec_req_value;
    logic              motor_req_write;
    logic              motor_req_value;
    logic              dir_write;
    logic              dir_forward;
  } cmd_t;

  // drive levels and status after one tick
  typedef struct packed {
    logic        elec_power;
    logic        motor_power;
    logic [7:0]  speed_out;
    logic        forward_contact;
    logic        reverse_contact;
    logic        moving_forward;
    logic [1:0]  seq_step;
    logic [15:0] counts_per_interval;
  } res_t;

  // configuration registers
  typedef struct packed {
    logic [15:0] meas_interval_ms;
    logic [15:0] settle_time_ms;
  } cfg_t;

endpackage

// ===== sv/mrs_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_seq
// Controller state and per-tick update: power follow, hall count latch and
// the reversal step sequencer. The result reflects the state after the tick.
// ----------------------------------------------------------------------------
module mrs_seq #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  mrs_pkg::cmd_t cmd_i,
  input  mrs_pkg::cfg_t cfg_i,
  output mrs_pkg::res_t res_o
);

  localparam int unsigned CMP_W = (TIME_BITS > 17) ? TIME_BITS : 17;

  typedef enum logic [1:0] {
    STEP_IDLE           = 2'd0,
    STEP_RELEASE        = 2'd1,
    STEP_RESUME_CONTACT = 2'd2,
    STEP_RESUME_SPEED   = 2'd3
  } step_e;

  logic [TIME_BITS-1:0] now_q, now_d;
  logic [TIME_BITS-1:0] int_start_q, int_start_d;
  logic [TIME_BITS-1:0] next_time_q, next_time_d;
  logic [TIME_BITS-1:0] rev_start_q, rev_start_d;
  logic [15:0]          accum_q, accum_d;
  logic [15:0]          latched_q, latched_d;
  logic                 elec_on_q, elec_on_d;
  logic                 elec_req_q, elec_req_d;
  logic                 motor_on;
  logic                 motor_req_q, motor_req_d;
  logic [7:0]           speed_q, speed_d;
  logic [7:0]           saved_q, saved_d;
  logic                 ready_q, ready_d;
  logic                 fwd_req_q, fwd_req_d;
  logic                 is_fwd_q, is_fwd_d;
  logic                 fwd_rel_q, fwd_rel_d;
  logic                 rev_rel_q, rev_rel_d;
  step_e                step_q, step_d;

  // next state for one tick
  always_comb begin
    logic [16:0]          acc_sum;
    logic [TIME_BITS-1:0] el_int;
    logic [TIME_BITS-1:0] el_step;
    logic [TIME_BITS-1:0] el_rev;
    logic [CMP_W-1:0]     stop_lim;
    logic                 timed_out;
    logic                 due;

    now_d       = now_q + TIME_BITS'(1);
    int_start_d = int_start_q;
    next_time_d = next_time_q;
    rev_start_d = rev_start_q;
    latched_d   = latched_q;
    elec_on_d   = elec_on_q;
    elec_req_d  = elec_req_q;
    motor_req_d = motor_req_q;
    speed_d     = speed_q;
    saved_d     = saved_q;
    ready_d     = ready_q;
    fwd_req_d   = fwd_req_q;
    is_fwd_d    = is_fwd_q;
    fwd_rel_d   = fwd_rel_q;
    rev_rel_d   = rev_rel_q;
    step_d      = step_q;

    // saturating hall pulse count
    acc_sum = {1'b0, accum_q} + {9'd0, cmd_i.hall_pulses};
    accum_d = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];

    // commands: speed first, then the requests
    if (cmd_i.speed_write) begin
      if (!cmd_i.speed_value[8] && (cmd_i.speed_value[7:0] != 8'd0)) begin
        ready_d = 1'b1;
      end
      speed_d = cmd_i.speed_value[8] ? 8'd0 : cmd_i.speed_value[7:0];
    end
    if (cmd_i.elec_req_write) begin
      elec_req_d = cmd_i.elec_req_value;
    end
    if (cmd_i.motor_req_write) begin
      motor_req_d = cmd_i.motor_req_value;
    end
    if (cmd_i.dir_write) begin
      fwd_req_d = cmd_i.dir_forward;
    end

    // power switches follow requests
    motor_on = motor_req_d;
    if (elec_req_d && !elec_on_q) begin
      ready_d   = 1'b0;
      elec_on_d = 1'b1;
    end else if (!elec_req_d) begin
      elec_on_d = 1'b0;
    end

    // measurement interval latch
    el_int = now_d - int_start_q;
    if (CMP_W'(el_int) >= CMP_W'(cfg_i.meas_interval_ms)) begin
      latched_d   = accum_d;
      int_start_d = now_d;
      accum_d     = 16'd0;
    end

    // reversal sequencer, one step per tick at most
    el_step   = now_d - next_time_q;
    el_rev    = now_d - rev_start_q;
    stop_lim  = CMP_W'({cfg_i.meas_interval_ms, 1'b0});
    timed_out = CMP_W'(el_rev) > stop_lim;
    due       = (step_q == STEP_IDLE) || !el_step[TIME_BITS-1];

    if ((fwd_req_d != is_fwd_q) && ready_d && due) begin
      case (step_q)
        STEP_IDLE: begin
          saved_d     = speed_d;
          rev_start_d = now_d;
          speed_d     = 8'd0;
          step_d      = STEP_RELEASE;
          next_time_d = now_d + TIME_BITS'(cfg_i.settle_time_ms);
        end
        STEP_RELEASE: begin
          if ((latched_d == 16'd0) || timed_out) begin
            fwd_rel_d   = 1'b0;
            rev_rel_d   = 1'b0;
            step_d      = STEP_RESUME_CONTACT;
            if (timed_out) begin
              motor_req_d = 1'b0;
            end
            next_time_d = now_d + TIME_BITS'(cfg_i.settle_time_ms);
          end
        end
        STEP_RESUME_CONTACT: begin
          if (!motor_on) begin
            speed_d     = 8'd0;
            motor_req_d = 1'b1;
          end else begin
            fwd_rel_d = fwd_req_d;
            rev_rel_d = !fwd_req_d;
            step_d    = STEP_RESUME_SPEED;
          end
          next_time_d = now_d + TIME_BITS'(cfg_i.settle_time_ms);
        end
        STEP_RESUME_SPEED: begin
          if (saved_q != 8'd0) begin
            ready_d = 1'b1;
          end
          speed_d  = saved_q;
          is_fwd_d = !is_fwd_q;
          step_d   = STEP_IDLE;
        end
        default: begin
          step_d = STEP_IDLE;
        end
      endcase
    end
  end

  // result after this tick
  always_comb begin
    res_o.elec_power          = elec_on_d;
    res_o.motor_power         = motor_on;
    res_o.speed_out           = speed_d;
    res_o.forward_contact     = fwd_rel_d;
    res_o.reverse_contact     = rev_rel_d;
    res_o.moving_forward      = is_fwd_d;
    res_o.seq_step            = step_d;
    res_o.counts_per_interval = latched_d;
  end

  // state registers, updated once per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      int_start_q <= '0;
      next_time_q <= '0;
      rev_start_q <= '0;
      accum_q     <= '0;
      latched_q   <= '0;
      elec_on_q   <= 1'b0;
      elec_req_q  <= 1'b0;
      motor_req_q <= 1'b0;
      speed_q     <= '0;
      saved_q     <= '0;
      ready_q     <= 1'b0;
      fwd_req_q   <= 1'b1;
      is_fwd_q    <= 1'b1;
      fwd_rel_q   <= 1'b1;
      rev_rel_q   <= 1'b0;
      step_q      <= STEP_IDLE;
    end else if (step_i) begin
      now_q       <= now_d;
      int_start_q <= int_start_d;
      next_time_q <= next_time_d;
      rev_start_q <= rev_start_d;
      accum_q     <= accum_d;
      latched_q   <= latched_d;
      elec_on_q   <= elec_on_d;
      elec_req_q  <= elec_req_d;
      motor_req_q <= motor_req_d;
      speed_q     <= speed_d;
      saved_q     <= saved_d;
      ready_q     <= ready_d;
      fwd_req_q   <= fwd_req_d;
      is_fwd_q    <= is_fwd_d;
      fwd_rel_q   <= fwd_rel_d;
      rev_rel_q   <= rev_rel_d;
      step_q      <= step_d;
    end
  end

`ifndef ASSERT_OFF
  // both relays are never closed together
  a_relay_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fwd_rel_q && rev_rel_q))
    else $error("both direction relays closed");

  // contacts stay open while waiting for motor power
  a_open_resume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_RESUME_CONTACT) |-> (!fwd_rel_q && !rev_rel_q))
    else $error("contact closed before motor power restored");

  // before contacts open, the closed relay matches the established direction
  a_relay_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((step_q == STEP_IDLE) || (step_q == STEP_RELEASE)) |->
      ((fwd_rel_q == is_fwd_q) && (rev_rel_q == !is_fwd_q)))
    else $error("relay does not match established direction");
`endif

endmodule

// ===== sv/motor_reversal_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_reversal_sequencer_core
// Millisecond-tick motor controller with power follow, hall count latch and
// a safe direction reversal sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Each beat on the s_axis channel is one millisecond tick carrying hall
//   pulses and optional speed, power and direction commands. Each beat
//   yields exactly one m_axis beat with the drive levels and status after
//   that tick.
//   The result is registered: a beat accepted at one edge is offered on m_axis
//   from the next cycle. One beat is accepted every cycle while the output is
//   not stalled; the tick update is one pass through mrs_seq's state registers.
//   The output register frees when its beat is taken, so s_axis_tready stays
//   high while m_axis_tready is high. When the receiver stalls, the result
//   holds and s_axis_tready drops until it is taken.
//   Reset clears all state but the output payload: time and counts zero,
//   power off, speed zero, forward direction with the forward relay closed,
//   sequencer idle, and the registers at meas_interval_ms 1000 and
//   settle_time_ms 500. Configuration writes through cfg_we_i take effect
//   at the next edge and are meant while no beat is in flight.
// ----------------------------------------------------------------------------
module motor_reversal_sequencer_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: hall_pulses[7:0], speed_write[8], speed_value[17:9],
  //        elec_req_write[18], elec_req_value[19], motor_req_write[20],
  //        motor_req_value[21], dir_write[22], dir_forward[23]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mrs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tdata: elec_power[0], motor_power[1], speed_out[9:2],
  //        forward_contact[10], reverse_contact[11], moving_forward[12],
  //        seq_step[14:13], counts_per_interval[30:15], zero[31]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mrs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [15:0]                     cfg_data_i
);

  logic          in_beat;
  mrs_pkg::cmd_t cmd;
  mrs_pkg::cfg_t cfg_q;
  mrs_pkg::res_t res;
  mrs_pkg::res_t out_q;
  logic          out_valid_q;

  // accept while the output register is empty or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // unpack the command beat
  always_comb begin
    cmd.hall_pulses     = s_axis_tdata[7:0];
    cmd.speed_write     = s_axis_tdata[8];
    cmd.speed_value     = s_axis_tdata[17:9];
    cmd.elec_req_write  = s_axis_tdata[18];
    cmd.elec_req_value  = s_axis_tdata[19];
    cmd.motor_req_write = s_axis_tdata[20];
    cmd.motor_req_value = s_axis_tdata[21];
    cmd.dir_write       = s_axis_tdata[22];
    cmd.dir_forward     = s_axis_tdata[23];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.meas_interval_ms <= 16'd1000;
      cfg_q.settle_time_ms   <= 16'd500;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mrs_pkg::CFG_MEAS_INTERVAL: cfg_q.meas_interval_ms <= cfg_data_i;
        mrs_pkg::CFG_SETTLE_TIME:   cfg_q.settle_time_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mrs_seq #(
    .TIME_BITS (TIME_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_beat),
    .cmd_i  (cmd),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_q <= res;
    end
  end

  // pack the result beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0,
                          out_q.counts_per_interval,
                          out_q.seq_step,
                          out_q.moving_forward,
                          out_q.reverse_contact,
                          out_q.forward_contact,
                          out_q.speed_out,
                          out_q.motor_power,
                          out_q.elec_power};

endmodule
